// ----- design/swtq_pkg.sv -----
// Package with the shared types and constants of the sorted wakeup timer queue.
`timescale 1ns / 1ps
`default_nettype none

package swtq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH    = 16;
    localparam int DEFAULT_THREAD_ID_BITS = 8;
    localparam int OP_FIFO_DEPTH          = 2;
    localparam int RES_FIFO_DEPTH         = 2;

    localparam logic CMD_SLEEP       = 1'b0;
    localparam logic CMD_TICK        = 1'b1;
    localparam logic STATUS_WOKEN    = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        thread_id;
        logic [5:0]        priority_req;
        logic signed [31:0] sleep_ticks;
    } in_item_t;

    typedef struct packed {
        logic [7:0] woken_id;
        logic       status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic        is_tick;
        logic [7:0]  thread_id;
        logic [5:0]  prio;
        logic [30:0] duration;
    } op_t;

endpackage

`default_nettype wire

// ----- design/swtq_fifo.sv -----
// Small first-in first-out buffer with show-ahead read data.
`timescale 1ns / 1ps
`default_nettype none

module swtq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = data_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/swtq_front.sv -----
// Front end that accepts requests, drops idle sleeps and queues operations.
`timescale 1ns / 1ps
`default_nettype none

module swtq_front
    import swtq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t request,
    output logic          op_valid,
    input  wire logic     op_pop,
    output op_t           op
);

    logic fifo_empty;
    logic sleep_ok;
    logic keep;
    op_t  op_in;
    logic [$bits(op_t)-1:0] op_bits;

    // A sleep with a zero or negative duration is accepted and discarded.
    assign sleep_ok = !request.sleep_ticks[31] && (request.sleep_ticks != 32'sd0);
    assign keep     = (request.cmd == CMD_TICK) || sleep_ok;

    always_comb
    begin
        op_in.is_tick   = (request.cmd == CMD_TICK);
        op_in.thread_id = request.thread_id;
        op_in.prio      = request.priority_req;
        op_in.duration  = request.sleep_ticks[30:0];
    end

    swtq_fifo #(
        .WIDTH($bits(op_t)),
        .DEPTH(OP_FIFO_DEPTH)
    ) u_op_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push && keep),
        .wr_data(op_in),
        .full   (full),
        .rd_en  (op_pop),
        .rd_data(op_bits),
        .empty  (fifo_empty)
    );

    assign op       = op_t'(op_bits);
    assign op_valid = !fifo_empty;

endmodule

`default_nettype wire

// ----- design/swtq_back.sv -----
// Back end that keeps the sorted sleep queue, the tick counter and the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module swtq_back
    import swtq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH,
    parameter int THREAD_ID_BITS = DEFAULT_THREAD_ID_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  op_valid,
    input  wire op_t   op,
    output logic       op_pop,
    output logic       empty,
    input  wire logic  pop,
    output out_item_t  result
);

    localparam int IDXW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SECOND = (QUEUE_DEPTH > 1) ? 1 : 0;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_INSERT  = 2'd1;
    localparam logic [1:0] ST_RELEASE = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [63:0]               tick_reg, tick_next;
    logic [CNTW-1:0]           count_reg, count_next;
    logic [IDXW-1:0]           idx_reg, idx_next;
    logic [63:0]               new_wake_reg, new_wake_next;
    logic [THREAD_ID_BITS-1:0] new_id_reg, new_id_next;
    logic [5:0]                new_prio_reg, new_prio_next;

    logic [63:0]               wake_reg [QUEUE_DEPTH];
    logic [THREAD_ID_BITS-1:0] tid_reg  [QUEUE_DEPTH];
    logic [5:0]                prio_reg [QUEUE_DEPTH];

    logic [IDXW-1:0]           prev_idx;
    logic [63:0]               prev_wake;
    logic [5:0]                prev_prio;
    logic                      new_first;
    logic                      head_due;
    logic                      second_due;
    logic [THREAD_ID_BITS-1:0] op_tid;
    logic [23:0]               id_wide_in;
    logic [23:0]               id_wide_out;
    logic [THREAD_ID_BITS-1:0] res_tid;
    logic                      do_release;
    logic                      do_move;
    logic                      do_place;
    logic                      res_push;
    logic                      res_full;
    out_item_t                 res_data;
    logic [$bits(out_item_t)-1:0] res_bits;

    assign id_wide_in = {16'd0, op.thread_id};
    assign op_tid     = id_wide_in[THREAD_ID_BITS-1:0];

    assign prev_idx   = idx_reg - 1'b1;
    assign prev_wake  = wake_reg[prev_idx];
    assign prev_prio  = prio_reg[prev_idx];
    assign new_first  = (new_wake_reg != prev_wake) ? (new_wake_reg < prev_wake)
                                                    : (new_prio_reg > prev_prio);

    assign head_due   = (count_reg != '0) && (wake_reg[0] <= tick_reg);
    assign second_due = (count_reg > CNTW'(1)) && (wake_reg[SECOND] <= tick_reg);

    assign id_wide_out = 24'(res_tid);

    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        new_wake_next = new_wake_reg;
        new_id_next   = new_id_reg;
        new_prio_next = new_prio_reg;
        op_pop        = 1'b0;
        do_release    = 1'b0;
        do_move       = 1'b0;
        do_place      = 1'b0;
        res_push      = 1'b0;
        res_tid       = tid_reg[0];
        res_data.status = STATUS_WOKEN;
        res_data.last   = !second_due;

        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.is_tick)
                    begin
                        op_pop     = 1'b1;
                        tick_next  = tick_reg + 64'd1;
                        state_next = ST_RELEASE;
                    end
                    else if (count_reg == CNTW'(QUEUE_DEPTH))
                    begin
                        res_tid         = op_tid;
                        res_data.status = STATUS_REJECTED;
                        res_data.last   = 1'b1;
                        if (!res_full)
                        begin
                            res_push = 1'b1;
                            op_pop   = 1'b1;
                        end
                    end
                    else
                    begin
                        op_pop        = 1'b1;
                        new_wake_next = tick_reg + 64'(op.duration);
                        new_id_next   = op_tid;
                        new_prio_next = op.prio;
                        idx_next      = count_reg[IDXW-1:0];
                        state_next    = ST_INSERT;
                    end
                end
            end
            ST_INSERT:
            begin
                if ((idx_reg == '0) || !new_first)
                begin
                    do_place   = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    do_move  = 1'b1;
                    idx_next = prev_idx;
                end
            end
            ST_RELEASE:
            begin
                if (!head_due)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_full)
                begin
                    res_push   = 1'b1;
                    do_release = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_data.woken_id = id_wide_out[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_wake_reg <= new_wake_next;
        new_id_reg   <= new_id_next;
        new_prio_reg <= new_prio_next;
    end

    always_ff @(posedge clk)
    begin
        if (do_release)
        begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++)
            begin
                wake_reg[j] <= wake_reg[j + 1];
                tid_reg[j]  <= tid_reg[j + 1];
                prio_reg[j] <= prio_reg[j + 1];
            end
        end
        else if (do_move)
        begin
            wake_reg[idx_reg] <= prev_wake;
            tid_reg[idx_reg]  <= tid_reg[prev_idx];
            prio_reg[idx_reg] <= prev_prio;
        end
        else if (do_place)
        begin
            wake_reg[idx_reg] <= new_wake_reg;
            tid_reg[idx_reg]  <= new_id_reg;
            prio_reg[idx_reg] <= new_prio_reg;
        end
    end

    swtq_fifo #(
        .WIDTH($bits(out_item_t)),
        .DEPTH(RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_data),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_bits),
        .empty  (empty)
    );

    assign result = out_item_t'(res_bits);

endmodule

`default_nettype wire

// ----- design/sorted_wakeup_timer_queue.sv -----
// Top level of the sorted wakeup timer queue.
// The request channel takes a transaction when push is high and full is low.
// A transaction is either a timer tick or a sleep request with a thread id,
// a priority and a duration; a sleep with a zero or negative duration is
// accepted and discarded without a result.
// Accepted operations wait in a two-entry operation queue and are carried out
// one at a time by the back end, which holds the sorted sleep queue.
// A sleep is inserted by walking from the tail one entry per cycle until it
// reaches its place in the sorted sleep queue.
// A tick advances the tick counter and then releases every due thread.
// A sleep that finds the queue full produces one result with status set.
// Results wait in a two-entry result queue; the oldest one is on result while
// empty is low and leaves on a cycle with pop high.
// When the receiver stops popping, the result queue fills, the back end waits,
// the operation queue fills and full rises, so nothing is lost.
// Reset clears the tick counter and empties both queues and the sleep queue.
`timescale 1ns / 1ps
`default_nettype none

module sorted_wakeup_timer_queue
    import swtq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH,
    parameter int THREAD_ID_BITS = DEFAULT_THREAD_ID_BITS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t request,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    logic op_valid;
    logic op_pop;
    op_t  op;

    swtq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .op_valid(op_valid),
        .op_pop  (op_pop),
        .op      (op)
    );

    swtq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_valid(op_valid),
        .op      (op),
        .op_pop  (op_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
